### sv/sice_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the small integer execute core.
// Used by sice_rf, sice_dmem and small_integer_core_execute_core; no dependencies.

package sice_pkg;

  // Default sizes, handed down through the top-level parameters
  localparam int REG_COUNT_DEF  = 32;
  localparam int MEM_WORDS_DEF  = 4096;
  localparam int PROG_DEPTH_DEF = 256;

  // Decoded operation codes; code 15 is unused and acts as a nop
  typedef enum logic [3:0] {
    OP_NOP  = 4'd0,
    OP_SUB  = 4'd1,
    OP_BLT  = 4'd2,
    OP_BGT  = 4'd3,
    OP_MV   = 4'd4,
    OP_BGE  = 4'd5,
    OP_LI   = 4'd6,
    OP_ADDI = 4'd7,
    OP_SUBI = 4'd8,
    OP_LW   = 4'd9,
    OP_SW   = 4'd10,
    OP_SLT  = 4'd11,
    OP_J    = 4'd12,
    OP_BNE  = 4'd13,
    OP_EXIT = 4'd14
  } op_e;

  // One decoded instruction
  typedef struct packed {
    logic [3:0]         op;
    logic [4:0]         dest_reg;
    logic [4:0]         src_a;
    logic [4:0]         src_b;
    logic signed [31:0] immediate;
    logic [7:0]         branch_target;
  } in_item_t;

  // One retirement record
  typedef struct packed {
    logic [7:0]         next_pc;
    logic               reg_written;
    logic [4:0]         written_index;
    logic signed [31:0] written_value;
    logic               mem_written;
    logic [11:0]        mem_address;
    logic               halted;
    logic               address_error;
  } out_item_t;

  // Register file write port
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

endpackage

### sv/sice_rf.sv
`timescale 1ns / 1ps
// Register file: two registered read ports, one write port, per-entry valid bits.
// Depends on sice_pkg for the write port struct.

module sice_rf #(
  parameter int REG_COUNT = sice_pkg::REG_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [4:0]       rd_a_idx_i,
  input  logic [4:0]       rd_b_idx_i,
  output logic [31:0]      rd_a_data_o,
  output logic [31:0]      rd_b_data_o,
  input  sice_pkg::rf_wr_t wr_i
);

  localparam int IW = $clog2(REG_COUNT);

  logic [31:0]          mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic [31:0]          rdata_a_q, rdata_b_q;
  logic                 rvld_a_q, rvld_b_q;
  logic                 a_ok, b_ok, w_ok;

  // Indexes at or above the register count read as zero and drop writes
  assign a_ok = (32'(rd_a_idx_i) < 32'(REG_COUNT));
  assign b_ok = (32'(rd_b_idx_i) < 32'(REG_COUNT));
  assign w_ok = wr_i.en && (32'(wr_i.idx) < 32'(REG_COUNT));

  // Storage array and read data
  always_ff @(posedge clk_i) begin
    if (w_ok) begin
      mem_q[wr_i.idx[IW-1:0]] <= wr_i.data;
    end
    rdata_a_q <= mem_q[rd_a_idx_i[IW-1:0]];
    rdata_b_q <= mem_q[rd_b_idx_i[IW-1:0]];
  end

  // Valid bits: an entry never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvld_a_q <= 1'b0;
      rvld_b_q <= 1'b0;
    end else begin
      if (w_ok) begin
        vld_q[wr_i.idx[IW-1:0]] <= 1'b1;
      end
      rvld_a_q <= a_ok && vld_q[rd_a_idx_i[IW-1:0]];
      rvld_b_q <= b_ok && vld_q[rd_b_idx_i[IW-1:0]];
    end
  end

  assign rd_a_data_o = rvld_a_q ? rdata_a_q : '0;
  assign rd_b_data_o = rvld_b_q ? rdata_b_q : '0;

endmodule

### sv/sice_dmem.sv
`timescale 1ns / 1ps
// Word data memory, single port with registered read, zero-fill sweep after reset.
// Depends on sice_pkg for the default size.

module sice_dmem #(
  parameter int MEM_WORDS = sice_pkg::MEM_WORDS_DEF,
  parameter int AW        = $clog2(MEM_WORDS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [31:0]   wdata_i,
  output logic [31:0]   rdata_o,
  output logic          busy_o
);

  logic [31:0]   mem_q [MEM_WORDS];
  logic [31:0]   rdata_q;
  logic          busy_q;
  logic [AW-1:0] clr_addr_q;

  // Clear sweep: one word per cycle from reset until the last word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      if (clr_addr_q == AW'(MEM_WORDS - 1)) begin
        busy_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  // Array access
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (!busy_q && en_i && !we_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

### sv/small_integer_core_execute_core.sv
`timescale 1ns / 1ps
// Top level of the small integer execute core: execute and retire stages.
// Depends on sice_pkg, sice_rf and sice_dmem.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one decoded
//   instruction per item; output channel (out_valid_o / out_ready_i /
//   out_item_o) returns one retirement record per item, in order.
//   Path: an accepted item is held in the execute register, using the register
//   file read made at the accepting edge, then its record moves to the retire
//   register, from which it is valid.
//   Throughput: one item per cycle while out_ready_i is high and the memory
//   sweep is done. The register file read ports are re-read every cycle and the
//   pending and last write are forwarded, so dependent items follow back to back.
//   Reset: registers, pc and halt flag clear at once; the data memory is then
//   swept to zero, all MEM_WORDS words (4096 by default), with in_ready_o low.
//   Stall: when out_ready_i is low the retire register holds its item; the
//   execute stage still fills once, after which in_ready_o drops.
//   After exit every later item is retired with no effect and halted set.

module small_integer_core_execute_core #(
  parameter int REG_COUNT  = sice_pkg::REG_COUNT_DEF,
  parameter int MEM_WORDS  = sice_pkg::MEM_WORDS_DEF,
  parameter int PROG_DEPTH = sice_pkg::PROG_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sice_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sice_pkg::out_item_t out_item_o
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam int PW = $clog2(PROG_DEPTH);

  // Pipeline control
  logic accept, s1_adv;
  logic s1_valid_q, s2_valid_q;
  sice_pkg::in_item_t  s1_item_q;
  sice_pkg::out_item_t s2_out_q, s1_out;
  logic s2_load_q, s1_load;
  logic wb_pend_q;

  // Architectural state outside the memories
  logic [PW-1:0] pc_q;
  logic          halt_q;

  // Register file and forwarding
  logic [4:0]       rd_a_idx, rd_b_idx;
  logic [31:0]      rf_a, rf_b, opa, opb, s2_wval;
  sice_pkg::rf_wr_t rf_wr;
  logic             byp_vld_q;
  logic [4:0]       byp_idx_q;
  logic [31:0]      byp_val_q;

  // Data memory
  logic          dm_en, dm_we, dm_busy;
  logic [31:0]   dm_rdata;

  // Execute temporaries
  logic [31:0]   ea;
  logic          aerr_c, lt_ab, lt_ba, dest_ok;
  logic [15:0]   tgt;
  logic [PW-1:0] pc_inc, nxt;
  logic          wr, mw, aerr, is_exit, is_mem;
  logic [31:0]   val;

  assign s1_adv     = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o = !dm_busy && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  // Read addresses follow the item that will sit in execute next cycle
  assign rd_a_idx = accept ? in_item_i.src_a : s1_item_q.src_a;
  assign rd_b_idx = accept ? in_item_i.src_b : s1_item_q.src_b;

  sice_rf #(
    .REG_COUNT(REG_COUNT)
  ) u_rf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_a_idx_i (rd_a_idx),
    .rd_b_idx_i (rd_b_idx),
    .rd_a_data_o(rf_a),
    .rd_b_data_o(rf_b),
    .wr_i       (rf_wr)
  );

  // Retire stage writes back in its first cycle
  assign s2_wval    = s2_load_q ? dm_rdata : 32'(s2_out_q.written_value);
  assign rf_wr.en   = wb_pend_q;
  assign rf_wr.idx  = s2_out_q.written_index;
  assign rf_wr.data = s2_wval;

  // Operand forwarding: pending write first, then the write of the last edge
  always_comb begin
    if (wb_pend_q && s2_out_q.written_index == s1_item_q.src_a) begin
      opa = s2_wval;
    end else if (byp_vld_q && byp_idx_q == s1_item_q.src_a) begin
      opa = byp_val_q;
    end else begin
      opa = rf_a;
    end
    if (wb_pend_q && s2_out_q.written_index == s1_item_q.src_b) begin
      opb = s2_wval;
    end else if (byp_vld_q && byp_idx_q == s1_item_q.src_b) begin
      opb = byp_val_q;
    end else begin
      opb = rf_b;
    end
  end

  // Shared address and compare logic
  assign ea      = opa + 32'(s1_item_q.immediate);
  assign aerr_c  = ea[31] || (ea >= 32'(MEM_WORDS));
  assign lt_ab   = ($signed(opa) < $signed(opb));
  assign lt_ba   = ($signed(opb) < $signed(opa));
  assign dest_ok = (32'(s1_item_q.dest_reg) < 32'(REG_COUNT));
  assign pc_inc  = (pc_q == PW'(PROG_DEPTH - 1)) ? '0 : pc_q + PW'(1);

  // Branch target modulo program depth (quotient stays below 16)
  always_comb begin
    tgt = 16'(s1_item_q.branch_target);
    for (int k = 3; k >= 0; k--) begin
      if (tgt >= 16'(PROG_DEPTH << k)) begin
        tgt = tgt - 16'(PROG_DEPTH << k);
      end
    end
  end

  // Execute decoder
  always_comb begin
    nxt     = pc_inc;
    wr      = 1'b0;
    mw      = 1'b0;
    aerr    = 1'b0;
    is_exit = 1'b0;
    is_mem  = 1'b0;
    val     = '0;
    if (halt_q) begin
      nxt = pc_q;
    end else begin
      unique case (sice_pkg::op_e'(s1_item_q.op))
        sice_pkg::OP_SUB:  begin wr = 1'b1; val = opa - opb; end
        sice_pkg::OP_MV:   begin wr = 1'b1; val = opa; end
        sice_pkg::OP_LI:   begin wr = 1'b1; val = 32'(s1_item_q.immediate); end
        sice_pkg::OP_ADDI: begin wr = 1'b1; val = ea; end
        sice_pkg::OP_SUBI: begin
          wr  = 1'b1;
          val = opa - 32'(s1_item_q.immediate);
        end
        sice_pkg::OP_SLT:  begin wr = 1'b1; val = {31'd0, lt_ab}; end
        sice_pkg::OP_BLT:  if (lt_ab) nxt = PW'(tgt);
        sice_pkg::OP_BGT:  if (lt_ba) nxt = PW'(tgt);
        sice_pkg::OP_BGE:  if (!lt_ab) nxt = PW'(tgt);
        sice_pkg::OP_BNE:  if (opa != opb) nxt = PW'(tgt);
        sice_pkg::OP_J:    nxt = PW'(tgt);
        sice_pkg::OP_LW:   begin is_mem = 1'b1; aerr = aerr_c; wr = !aerr_c; end
        sice_pkg::OP_SW:   begin is_mem = 1'b1; aerr = aerr_c; mw = !aerr_c; end
        sice_pkg::OP_EXIT: begin is_exit = 1'b1; nxt = pc_q; end
        sice_pkg::OP_NOP:  ;
        default:           ;
      endcase
    end
  end

  // Record for the retire stage; load data is filled in there
  always_comb begin
    s1_load              = (sice_pkg::op_e'(s1_item_q.op) == sice_pkg::OP_LW);
    s1_out               = '0;
    s1_out.next_pc       = 8'(nxt);
    s1_out.reg_written   = wr && dest_ok;
    s1_out.written_index = (wr && dest_ok) ? s1_item_q.dest_reg : '0;
    s1_out.written_value = (wr && dest_ok && !s1_load) ? val : '0;
    s1_out.mem_written   = mw;
    s1_out.mem_address   = is_mem ? ea[11:0] : '0;
    s1_out.halted        = halt_q || is_exit;
    s1_out.address_error = aerr;
    s1_load              = s1_load && wr && dest_ok;
  end

  // Data memory access from execute
  assign dm_en = s1_adv && is_mem && !aerr;
  assign dm_we = mw;

  sice_dmem #(
    .MEM_WORDS(MEM_WORDS),
    .AW       (AW)
  ) u_dmem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (dm_en),
    .we_i   (dm_we),
    .addr_i (ea[AW-1:0]),
    .wdata_i(opb),
    .rdata_o(dm_rdata),
    .busy_o (dm_busy)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wb_pend_q  <= 1'b0;
      byp_vld_q  <= 1'b0;
      pc_q       <= '0;
      halt_q     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        s2_valid_q <= 1'b0;
      end
      wb_pend_q <= s1_adv && s1_out.reg_written;
      byp_vld_q <= wb_pend_q;
      if (s1_adv) begin
        pc_q   <= nxt;
        halt_q <= halt_q || is_exit;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
    end
    if (s1_adv) begin
      s2_out_q  <= s1_out;
      s2_load_q <= s1_load;
    end
    byp_idx_q <= s2_out_q.written_index;
    byp_val_q <= s2_wval;
  end

  // Output record
  always_comb begin
    out_item_o = s2_out_q;
    if (s2_load_q) begin
      out_item_o.written_value = dm_rdata;
    end
  end
  assign out_valid_o = s2_valid_q;

`ifndef SYNTHESIS
  // No item enters while the data memory sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dm_busy |-> !in_ready_o)
    else $error("item accepted during memory clear");

  // Halt is sticky
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag dropped");

  // Write-back only happens for a record held in the retire stage
  a_wb_has_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_pend_q |-> (s2_valid_q && s2_out_q.reg_written))
    else $error("write-back without retire record");

  // An address fault performs no access
  a_fault_no_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.address_error) |->
      (!out_item_o.reg_written && !out_item_o.mem_written))
    else $error("access despite address fault");

  // A retire record in halt writes nothing and keeps the pc
  a_halt_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && halt_q) |=> (!s2_out_q.reg_written && !s2_out_q.mem_written &&
      s2_out_q.next_pc == $past(8'(pc_q))))
    else $error("write or pc change while halted");
`endif

endmodule

### tb/tb_small_integer_core_execute_core.sv
`timescale 1ns / 1ps
// Self-checking testbench of small_integer_core_execute_core: a scoreboard
// class predicts each retirement record from the accepted instructions.
// Depends on sice_pkg and the core; drives both valid/ready channels.

// Predicts records from accepted instructions and checks records in order
class retire_scoreboard;
  logic [31:0]         regs  [sice_pkg::REG_COUNT_DEF];
  logic [31:0]         words [sice_pkg::MEM_WORDS_DEF];
  logic [7:0]          pc;
  bit                  halt_seen;
  sice_pkg::out_item_t expected_q[$];
  int errors;
  int checked;
  int loads;
  int stores;
  int addr_errs;
  int taken;
  int ignored;

  function new();
    foreach (regs[i]) regs[i] = '0;
    foreach (words[i]) words[i] = '0;
    pc        = '0;
    halt_seen = 1'b0;
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  // Execute one instruction on the shadow state and queue its record
  function void note_input(sice_pkg::in_item_t it);
    sice_pkg::out_item_t rec;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] ea;
    logic [31:0] val;
    logic [7:0]  nxt;
    bit          wr;
    bit          mw;
    bit          aerr;
    bit          jump;
    a    = regs[it.src_a];
    b    = regs[it.src_b];
    nxt  = pc + 8'd1;
    ea   = '0;
    val  = '0;
    wr   = 1'b0;
    mw   = 1'b0;
    aerr = 1'b0;
    jump = 1'b0;
    if (halt_seen) begin
      nxt = pc;
      ignored++;
    end else begin
      case (it.op) inside
        sice_pkg::OP_SUB:  begin wr = 1'b1; val = a - b; end
        sice_pkg::OP_MV:   begin wr = 1'b1; val = a; end
        sice_pkg::OP_LI:   begin wr = 1'b1; val = it.immediate; end
        sice_pkg::OP_ADDI: begin wr = 1'b1; val = a + it.immediate; end
        sice_pkg::OP_SUBI: begin wr = 1'b1; val = a - it.immediate; end
        sice_pkg::OP_SLT:  begin
          wr  = 1'b1;
          val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        end
        sice_pkg::OP_BLT:  jump = $signed(a) < $signed(b);
        sice_pkg::OP_BGT:  jump = $signed(b) < $signed(a);
        sice_pkg::OP_BGE:  jump = !($signed(a) < $signed(b));
        sice_pkg::OP_BNE:  jump = a != b;
        sice_pkg::OP_J:    jump = 1'b1;
        sice_pkg::OP_LW, sice_pkg::OP_SW: begin
          ea = a + it.immediate;
          if (ea[31] || ea >= 32'(sice_pkg::MEM_WORDS_DEF)) begin
            aerr = 1'b1;
            addr_errs++;
          end else if (it.op == sice_pkg::OP_LW) begin
            wr  = 1'b1;
            val = words[ea[11:0]];
            loads++;
          end else begin
            mw = 1'b1;
            words[ea[11:0]] = b;
            stores++;
          end
        end
        sice_pkg::OP_EXIT: begin
          halt_seen = 1'b1;
          nxt       = pc;
        end
        default: ;
      endcase
      if (jump) begin
        nxt = it.branch_target;
        taken++;
      end
      if (wr) regs[it.dest_reg] = val;
      pc = nxt;
    end
    rec.next_pc       = nxt;
    rec.reg_written   = wr;
    rec.written_index = wr ? it.dest_reg : 5'd0;
    rec.written_value = val;
    rec.mem_written   = mw;
    rec.mem_address   = ea[11:0];
    rec.halted        = halt_seen;
    rec.address_error = aerr;
    expected_q.insert(expected_q.size(), rec);
  endfunction

  function void compare(string field, logic [31:0] exp, logic [31:0] got);
    if (exp !== got) begin
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, exp, got);
    end
  endfunction

  // Compare one accepted record with the oldest prediction
  function void check_result(sice_pkg::out_item_t got);
    sice_pkg::out_item_t exp;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: record expected none, got 0x%0h", $time, got);
      return;
    end
    exp = expected_q.pop_front();
    checked++;
    compare("next_pc", exp.next_pc, got.next_pc);
    compare("reg_written", exp.reg_written, got.reg_written);
    compare("written_index", exp.written_index, got.written_index);
    compare("written_value", exp.written_value, got.written_value);
    compare("mem_written", exp.mem_written, got.mem_written);
    compare("mem_address", exp.mem_address, got.mem_address);
    compare("halted", exp.halted, got.halted);
    compare("address_error", exp.address_error, got.address_error);
  endfunction
endclass

module tb_small_integer_core_execute_core;

  localparam int         RANDOM_ITEMS = 1150;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic [3:0] OP_UNUSED    = 4'hF;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  sice_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  sice_pkg::out_item_t out_item_o;

  retire_scoreboard sb;
  bit hold_req;
  bit no_gaps;
  int sent;

  logic [3:0] arith_set [6] = '{sice_pkg::OP_LI, sice_pkg::OP_ADDI, sice_pkg::OP_SUBI,
                                sice_pkg::OP_SUB, sice_pkg::OP_MV, sice_pkg::OP_SLT};
  logic [3:0] ctrl_set  [7] = '{sice_pkg::OP_BLT, sice_pkg::OP_BGT, sice_pkg::OP_BGE,
                                sice_pkg::OP_BNE, sice_pkg::OP_J, sice_pkg::OP_NOP,
                                OP_UNUSED};

  small_integer_core_execute_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Small register pool so that items depend on each other
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 99) < 70) return 5'($urandom_range(0, 7));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] pick_imm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 32) - 16;
    if (r < 50) return $urandom_range(0, 4095);
    if (r < 60) return $urandom_range(0, 1) ? $urandom_range(4090, 4100) : -$urandom_range(0, 3);
    if (r < 70) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    return $urandom;
  endfunction

  // Any code but exit; the unused code takes its slot
  function automatic logic [3:0] pick_op();
    logic [3:0] v;
    v = 4'($urandom_range(0, 14));
    return (v == sice_pkg::OP_EXIT) ? OP_UNUSED : v;
  endfunction

  function automatic sice_pkg::in_item_t instr(logic [3:0] op, logic [4:0] rd,
                                               logic [4:0] ra, logic [4:0] rb,
                                               logic [31:0] imm, logic [7:0] tgt);
    sice_pkg::in_item_t it;
    it.op            = op;
    it.dest_reg      = rd;
    it.src_a         = ra;
    it.src_b         = rb;
    it.immediate     = imm;
    it.branch_target = tgt;
    return it;
  endfunction

  function automatic sice_pkg::in_item_t rand_instr(logic [3:0] op);
    logic [4:0] ra;
    logic [4:0] rb;
    ra = pick_reg();
    rb = ($urandom_range(0, 4) == 0) ? ra : pick_reg();
    return instr(op, pick_reg(), ra, rb, pick_imm(), 8'($urandom));
  endfunction

  // Offer one item, with an optional gap first, and wait for it to be taken
  task automatic send_instr(input sice_pkg::in_item_t it);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(it);
    sent++;
  endtask

  // Stop offering and wait until every predicted record has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Record monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
  end

  // Receiver: random ready runs and stalls, plus one long hold on request
  initial begin
    int run;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 99) < 60) begin
        out_ready_i <= 1'b1;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 30);
        repeat (run) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        run = 1 + pick_gap();
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // Stimulus
  initial begin
    sice_pkg::in_item_t it;
    logic [4:0]         base;
    int                 base_val;
    int                 sel;
    int                 n;
    bit                 hold_done;
    bit                 drain_done;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    rst_ni     = 1'b0;
    hold_req   = 1'b0;
    no_gaps    = 1'b0;
    sent       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: wraparound, signed compares, branches, pc wrap, memory edges
    send_instr(instr(sice_pkg::OP_LI,   5'd1,  5'd0,  5'd0, 32'h7fff_ffff, 8'd0));
    send_instr(instr(sice_pkg::OP_LI,   5'd2,  5'd0,  5'd0, 32'h8000_0000, 8'd0));
    send_instr(instr(sice_pkg::OP_ADDI, 5'd3,  5'd1,  5'd0, 32'd1, 8'd0));
    send_instr(instr(sice_pkg::OP_SUBI, 5'd4,  5'd2,  5'd0, 32'd1, 8'd0));
    send_instr(instr(sice_pkg::OP_SUB,  5'd5,  5'd2,  5'd1, 32'd0, 8'd0));
    send_instr(instr(sice_pkg::OP_MV,   5'd31, 5'd2,  5'd0, 32'd0, 8'd0));
    send_instr(instr(sice_pkg::OP_SLT,  5'd6,  5'd2,  5'd1, 32'd0, 8'd0));
    send_instr(instr(sice_pkg::OP_SLT,  5'd7,  5'd1,  5'd2, 32'd0, 8'd0));
    send_instr(instr(sice_pkg::OP_BLT,  5'd0,  5'd2,  5'd1, 32'd0, 8'd255));
    send_instr(instr(sice_pkg::OP_BGT,  5'd0,  5'd2,  5'd1, 32'd0, 8'd10));
    send_instr(instr(sice_pkg::OP_BGE,  5'd0,  5'd1,  5'd1, 32'd0, 8'd0));
    send_instr(instr(sice_pkg::OP_BNE,  5'd0,  5'd1,  5'd1, 32'd0, 8'd77));
    send_instr(instr(sice_pkg::OP_BNE,  5'd0,  5'd1,  5'd2, 32'd0, 8'd200));
    send_instr(instr(sice_pkg::OP_J,    5'd0,  5'd0,  5'd0, 32'd0, 8'd255));
    // pc wraps from the last index to zero
    send_instr(instr(sice_pkg::OP_NOP, 5'($urandom), 5'($urandom), 5'($urandom),
                     $urandom, 8'($urandom)));
    send_instr(instr(OP_UNUSED, 5'd9, 5'd1, 5'd2, 32'd5, 8'd3));
    // x0 is an ordinary register, used here as a base at the last word
    send_instr(instr(sice_pkg::OP_LI,   5'd0,  5'd0,  5'd0, 32'd4095, 8'd0));
    send_instr(instr(sice_pkg::OP_SW,   5'd0,  5'd0,  5'd1, 32'd0, 8'd0));
    send_instr(instr(sice_pkg::OP_LW,   5'd8,  5'd0,  5'd0, 32'd0, 8'd0));
    send_instr(instr(sice_pkg::OP_LW,   5'd9,  5'd0,  5'd0, 32'd1, 8'd0));
    send_instr(instr(sice_pkg::OP_SW,   5'd0,  5'd0,  5'd1, -32'sd4096, 8'd0));
    send_instr(instr(sice_pkg::OP_LI,   5'd10, 5'd0,  5'd0, 32'd0, 8'd0));
    send_instr(instr(sice_pkg::OP_LW,   5'd11, 5'd10, 5'd0, 32'd0, 8'd0));
    send_instr(instr(sice_pkg::OP_SW,   5'd0,  5'd1,  5'd2, 32'h8000_0000, 8'd0));
    send_instr(instr(sice_pkg::OP_LW,   5'd12, 5'd0,  5'd0, 32'h7fff_ffff, 8'd0));

    // Random: address setup followed by loads and stores, arithmetic runs, control items and noise
    while (sent < RANDOM_ITEMS) begin
      if (!hold_done && sent >= 300) begin
        // receiver holds off while the sender keeps offering
        hold_done = 1'b1;
        hold_req  = 1'b1;
        no_gaps   = 1'b1;
        repeat (80) send_instr(rand_instr(pick_op()));
      end
      if (!drain_done && sent >= 650) begin
        drain_done = 1'b1;
        drain();
      end
      no_gaps = (sent >= 850 && sent < 950);
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        base = pick_reg();
        n    = $urandom_range(0, 3);
        base_val = (n < 2) ? $urandom_range(0, 15) :
                   (n == 2) ? $urandom_range(4080, 4095) : $urandom_range(0, 4095);
        send_instr(instr(sice_pkg::OP_LI, base, pick_reg(), pick_reg(), base_val,
                         8'($urandom)));
        n = $urandom_range(1, 5);
        repeat (n) begin
          it = rand_instr($urandom_range(0, 1) ? sice_pkg::OP_LW : sice_pkg::OP_SW);
          it.src_a = base;
          if ($urandom_range(0, 99) < 85) it.immediate = $urandom_range(0, 16) - 4;
          send_instr(it);
        end
      end else if (sel < 70) begin
        n = $urandom_range(2, 6);
        repeat (n) send_instr(rand_instr(arith_set[$urandom_range(0, 5)]));
      end else if (sel < 85) begin
        send_instr(rand_instr(ctrl_set[$urandom_range(0, 6)]));
      end else begin
        // noise over the whole register range
        send_instr(instr(pick_op(), 5'($urandom), 5'($urandom), 5'($urandom),
                         $urandom, 8'($urandom)));
      end
    end
    no_gaps = 1'b0;

    // Exit, then items that must retire with no effect
    send_instr(rand_instr(sice_pkg::OP_EXIT));
    repeat (12) send_instr(rand_instr(4'($urandom_range(0, 15))));

    drain();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d instructions: %0d loads, %0d stores, %0d bad addresses,",
             sent, sb.loads, sb.stores, sb.addr_errs);
    $display("%0d jumps taken; checked %0d records, %0d of them retired after exit",
             sb.taken, sb.checked, sb.ignored);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_small_integer_core_execute_core OK");
    end else begin
      $display("tb_small_integer_core_execute_core NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d records outstanding", sb.outstanding());
    $display("tb_small_integer_core_execute_core NOT OK");
    $finish;
  end

endmodule
